// File: rtl/tleh_pkg.sv
// Package for the terminal line editor with history: sizes, codes, types
// and the history slot helper. Depends on nothing.
package tleh_pkg;

    localparam int LINE_BYTES    = 64;
    localparam int HISTORY_DEPTH = 8;

    localparam int LW  = $clog2(LINE_BYTES);
    localparam int HSW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int HAW = $clog2(HISTORY_DEPTH * LINE_BYTES);

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_BS     = 8'd8;
    localparam logic [7:0] CH_LOW    = 8'd32;
    localparam logic [7:0] CH_HIGH   = 8'd126;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;

    localparam logic [2:0] KIND_ECHO         = 3'd0;
    localparam logic [2:0] KIND_ERASE        = 3'd1;
    localparam logic [2:0] KIND_REDRAW_BEGIN = 3'd2;
    localparam logic [2:0] KIND_REDRAW_CHAR  = 3'd3;
    localparam logic [2:0] KIND_SUBMIT_CHAR  = 3'd4;
    localparam logic [2:0] KIND_SUBMIT_END   = 3'd5;

    localparam logic [1:0] ESC_NONE    = 2'd0;
    localparam logic [1:0] ESC_SEEN    = 2'd1;
    localparam logic [1:0] ESC_BRACKET = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_ECHO, ACT_ERASE, ACT_CLEAR, ACT_LOAD, ACT_SUBMIT
    } t_act;

    typedef enum logic [3:0] {
        OP_NONE, OP_DECODE, OP_LOAD_CHAR, OP_SUB_CHAR, OP_CMP_INIT,
        OP_ADV, OP_COPY_INIT, OP_COPY_CHAR, OP_END
    } t_op;

    typedef struct packed {
        logic take;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        t_act act;
        logic out_free;
        logic len_zero;
        logic idx_last;
        logic save_direct;
        logic mismatch;
    } t_status;

    function automatic logic [HSW-1:0] phys_slot(input logic [HSW-1:0] oldest,
                                                 input logic [HSW-1:0] pos);
        logic [HSW:0] sum;
        sum = {1'b0, oldest} + {1'b0, pos};
        if (sum >= (HSW+1)'(HISTORY_DEPTH)) begin
            sum = sum - (HSW+1)'(HISTORY_DEPTH);
        end
        return sum[HSW-1:0];
    endfunction

endpackage

// File: rtl/terminal_line_editor_history.sv
// Top level of the serial terminal line editor with command history.
// Depends on tleh_pkg, tleh_ctrl and tleh_dp (which holds two tleh_ram).
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_rx_byte
//  out     | output    | o_out_valid / i_out_ready  | o_kind, o_char_value,
//          |           |                            | o_line_length, o_last
//
// One byte is in work at a time; o_in_ready is high only when the sequencer
// is idle. A history step decodes, then reads and emits each redrawn char;
// Enter emits each submitted char, compares the line with the newest entry,
// copies it into history if it differs, then emits the end marker. Each char
// needs a read state first, as each RAM has one registered read port. The
// output register lets a new byte transfer while the last result still
// waits. Reset is synchronous, active low, needs no clearing pass; a stalled
// output holds the sequencer at its next emit.
module terminal_line_editor_history import tleh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_char_value,
    output logic [5:0] o_line_length,
    output logic       o_last
);
    t_cmd    cmd;
    t_status status;

    // sequence the passes over the line
    tleh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // hold the line, the history and the result register
    tleh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rx_byte     (i_rx_byte),
        .i_out_ready   (i_out_ready),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_char_value  (o_char_value),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );
endmodule

// File: rtl/tleh_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module tleh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/tleh_ctrl.sv
// Controller state machine of the line editor: sequences decode, redraw,
// submit, compare and copy passes. Depends on tleh_pkg.
module tleh_ctrl import tleh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECODE = 13'b0000000000010,
        S_LRD    = 13'b0000000000100,
        S_LEMIT  = 13'b0000000001000,
        S_SRD    = 13'b0000000010000,
        S_SEMIT  = 13'b0000000100000,
        S_CINIT  = 13'b0000001000000,
        S_CRD    = 13'b0000010000000,
        S_CCHK   = 13'b0000100000000,
        S_WINIT  = 13'b0001000000000,
        S_WRD    = 13'b0010000000000,
        S_WWR    = 13'b0100000000000,
        S_END    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.take = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_DECODE;
                    case (i_status.act)
                        ACT_LOAD:   n_state = i_status.len_zero ? S_IDLE : S_LRD;
                        ACT_SUBMIT: n_state = i_status.len_zero ? S_END : S_SRD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_LRD: n_state = S_LEMIT;
            S_LEMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_LOAD_CHAR;
                    n_state  = i_status.idx_last ? S_IDLE : S_LRD;
                end
            end
            S_SRD: n_state = S_SEMIT;
            S_SEMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_SUB_CHAR;
                    n_state  = i_status.idx_last ? S_CINIT : S_SRD;
                end
            end
            S_CINIT: begin
                o_cmd.op = OP_CMP_INIT;
                n_state  = i_status.save_direct ? S_WINIT : S_CRD;
            end
            S_CRD: n_state = S_CCHK;
            S_CCHK: begin
                if (i_status.mismatch) begin
                    n_state = S_WINIT;
                end else if (i_status.idx_last) begin
                    n_state = S_END;
                end else begin
                    o_cmd.op = OP_ADV;
                    n_state  = S_CRD;
                end
            end
            S_WINIT: begin
                o_cmd.op = OP_COPY_INIT;
                n_state  = S_WRD;
            end
            S_WRD: n_state = S_WWR;
            S_WWR: begin
                o_cmd.op = OP_COPY_CHAR;
                n_state  = i_status.idx_last ? S_END : S_WRD;
            end
            S_END: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_END;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: rtl/tleh_dp.sv
// Datapath of the line editor: edit and history RAMs, editor state,
// decode logic and the output register. Depends on tleh_pkg and tleh_ram.
module tleh_dp import tleh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_ready,
    output t_status    o_status,
    output logic       o_out_valid,
    output logic [2:0] o_kind,
    output logic [7:0] o_char_value,
    output logic [5:0] o_line_length,
    output logic       o_last
);
    logic [7:0]     r_byte;
    logic [LW-1:0]  r_len;
    logic [HCW-1:0] r_count;
    logic [HSW-1:0] r_oldest;
    logic [HSW-1:0] r_browse;
    logic           r_browsing;
    logic [1:0]     r_esc;
    logic [LW-1:0]  r_idx;
    logic [HSW-1:0] r_slot;
    logic [LW-1:0]  r_hlen [HISTORY_DEPTH];

    logic           r_ovalid;
    logic [2:0]     r_kind;
    logic [7:0]     r_char;
    logic [LW-1:0]  r_oline;
    logic           r_last;

    logic [7:0]     edit_rdata, hist_rdata;
    logic           edit_we, hist_we;
    logic [LW-1:0]  edit_waddr;
    logic [7:0]     edit_wdata;
    logic [HAW-1:0] hist_addr;

    t_act           d_act;
    logic [1:0]     d_esc;
    logic [HSW-1:0] d_pos, d_slot, newest_slot;
    logic [LW-1:0]  d_load_len;
    logic [HCW-1:0] down_next;
    logic           is_print, out_free, idx_last;
    logic           ovalid_set;

    assign out_free    = !r_ovalid || i_out_ready;
    assign idx_last    = (r_idx == r_len - 1'b1);
    assign newest_slot = phys_slot(r_oldest, HSW'(r_count - 1'b1));
    assign down_next   = HCW'(r_browse) + 1'b1;
    assign is_print    = (r_byte >= CH_LOW) && (r_byte <= CH_HIGH);

    always_comb begin
        d_act = ACT_NONE;
        d_esc = ESC_NONE;
        d_pos = r_browse;
        case (r_esc)
            ESC_SEEN: begin
                d_esc = (r_byte == CH_LBRACK) ? ESC_BRACKET : ESC_NONE;
            end
            ESC_BRACKET: begin
                if (r_byte == CH_UP && r_count != '0) begin
                    if (!r_browsing) begin
                        d_act = ACT_LOAD;
                        d_pos = HSW'(r_count - 1'b1);
                    end else if (r_browse != '0) begin
                        d_act = ACT_LOAD;
                        d_pos = r_browse - 1'b1;
                    end
                end else if (r_byte == CH_DOWN && r_count != '0 && r_browsing) begin
                    if (down_next >= r_count) begin
                        d_act = ACT_CLEAR;
                    end else begin
                        d_act = ACT_LOAD;
                        d_pos = HSW'(down_next);
                    end
                end
            end
            default: begin
                if (r_byte == CH_ESC) begin
                    d_esc = ESC_SEEN;
                end else if (r_byte == CH_CR || r_byte == CH_LF) begin
                    d_act = ACT_SUBMIT;
                end else if (r_byte == CH_DEL || r_byte == CH_BS) begin
                    if (r_len != '0) d_act = ACT_ERASE;
                end else if (is_print) begin
                    if (r_len != LW'(LINE_BYTES - 1)) d_act = ACT_ECHO;
                end
            end
        endcase
    end

    assign d_slot     = phys_slot(r_oldest, d_pos);
    assign d_load_len = r_hlen[d_slot];

    assign o_status.act         = d_act;
    assign o_status.out_free    = out_free;
    assign o_status.len_zero    = (d_act == ACT_LOAD) ? (d_load_len == '0) : (r_len == '0);
    assign o_status.idx_last    = idx_last;
    assign o_status.save_direct = (r_count == '0) || (r_hlen[newest_slot] != r_len);
    assign o_status.mismatch    = (edit_rdata != hist_rdata);

    // a new result is loaded into the output register
    assign ovalid_set = (i_cmd.op == OP_DECODE &&
                         d_act inside {ACT_ECHO, ACT_ERASE, ACT_CLEAR, ACT_LOAD}) ||
                        (i_cmd.op inside {OP_LOAD_CHAR, OP_SUB_CHAR, OP_END});

    assign edit_we    = (i_cmd.op == OP_DECODE && d_act == ACT_ECHO) ||
                        (i_cmd.op == OP_LOAD_CHAR);
    assign edit_waddr = (i_cmd.op == OP_DECODE) ? r_len : r_idx;
    assign edit_wdata = (i_cmd.op == OP_DECODE) ? r_byte : hist_rdata;
    assign hist_we    = (i_cmd.op == OP_COPY_CHAR);
    assign hist_addr  = HAW'(r_slot) * HAW'(LINE_BYTES) + HAW'(r_idx);

    tleh_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_edit (
        .i_clk   (i_clk),
        .i_we    (edit_we),
        .i_waddr (edit_waddr),
        .i_wdata (edit_wdata),
        .i_raddr (r_idx),
        .o_rdata (edit_rdata)
    );

    tleh_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH * LINE_BYTES)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_addr),
        .i_wdata (edit_rdata),
        .i_raddr (hist_addr),
        .o_rdata (hist_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_count    <= '0;
            r_oldest   <= '0;
            r_browse   <= '0;
            r_browsing <= 1'b0;
            r_esc      <= ESC_NONE;
            r_ovalid   <= 1'b0;
        end else begin
            if (ovalid_set) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_DECODE: begin
                    r_esc <= d_esc;
                    case (d_act)
                        ACT_ECHO: begin
                            r_len <= r_len + 1'b1;
                        end
                        ACT_ERASE: begin
                            r_len <= r_len - 1'b1;
                        end
                        ACT_CLEAR: begin
                            r_browsing <= 1'b0;
                            r_browse   <= '0;
                            r_len      <= '0;
                        end
                        ACT_LOAD: begin
                            r_browsing <= 1'b1;
                            r_browse   <= d_pos;
                            r_len      <= d_load_len;
                        end
                        ACT_SUBMIT: begin
                            r_browsing <= 1'b0;
                            r_browse   <= '0;
                        end
                        default: ;
                    endcase
                end
                OP_COPY_INIT: begin
                    if (r_count < HCW'(HISTORY_DEPTH)) begin
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_oldest <= (r_oldest == HSW'(HISTORY_DEPTH - 1)) ? '0
                                                                         : r_oldest + 1'b1;
                    end
                end
                OP_END: begin
                    r_len <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_byte <= i_rx_byte;
        case (i_cmd.op)
            OP_DECODE: begin
                r_idx  <= '0;
                r_last <= 1'b1;
                r_char <= 8'd0;
                case (d_act)
                    ACT_ECHO: begin
                        r_kind  <= KIND_ECHO;
                        r_char  <= r_byte;
                        r_oline <= r_len + 1'b1;
                    end
                    ACT_ERASE: begin
                        r_kind  <= KIND_ERASE;
                        r_oline <= r_len - 1'b1;
                    end
                    ACT_CLEAR: begin
                        r_kind  <= KIND_REDRAW_BEGIN;
                        r_oline <= '0;
                    end
                    ACT_LOAD: begin
                        r_kind  <= KIND_REDRAW_BEGIN;
                        r_oline <= d_load_len;
                        r_last  <= (d_load_len == '0);
                        r_slot  <= d_slot;
                    end
                    default: ;
                endcase
            end
            OP_LOAD_CHAR: begin
                r_kind  <= KIND_REDRAW_CHAR;
                r_char  <= hist_rdata;
                r_oline <= r_len;
                r_last  <= idx_last;
                r_idx   <= r_idx + 1'b1;
            end
            OP_SUB_CHAR: begin
                r_kind  <= KIND_SUBMIT_CHAR;
                r_char  <= edit_rdata;
                r_oline <= '0;
                r_last  <= 1'b0;
                r_idx   <= r_idx + 1'b1;
            end
            OP_CMP_INIT: begin
                r_slot <= newest_slot;
                r_idx  <= '0;
            end
            OP_ADV, OP_COPY_CHAR: r_idx <= r_idx + 1'b1;
            OP_COPY_INIT: begin
                r_idx <= '0;
                if (r_count < HCW'(HISTORY_DEPTH)) begin
                    r_slot <= phys_slot(r_oldest, HSW'(r_count));
                    r_hlen[phys_slot(r_oldest, HSW'(r_count))] <= r_len;
                end else begin
                    r_slot <= r_oldest;
                    r_hlen[r_oldest] <= r_len;
                end
            end
            OP_END: begin
                r_kind  <= KIND_SUBMIT_END;
                r_char  <= 8'd0;
                r_oline <= '0;
                r_last  <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_ovalid;
    assign o_kind        = r_kind;
    assign o_char_value  = r_char;
    assign o_line_length = 6'(r_oline);
    assign o_last        = r_last;
endmodule
